// ===== sv/lcpd_pkg.sv =====
package lcpd_pkg;

	// queue between front and back
	localparam int unsigned LCPD_QUEUE_DEPTH = 2;

	// register reset values, unsigned Q8.24
	localparam logic [31:0] GAIN_PROP_RST  = 32'h0100_0000;
	localparam logic [31:0] GAIN_DERIV_RST = 32'd1678;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_GAIN_PROP  = 1'b0,
		REG_GAIN_DERIV = 1'b1
	} reg_idx_t;

	// word passed from front to back
	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} item_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sh0000_7FFF_FFFF;
		lo = -48'sh0000_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// ===== sv/loadcell_compliance_pd_core.sv =====
// channel   direction  handshake          words
// input     in         push / full        stamp, four cell readings, pos_x/y/z
// result    out        empty / pop        target_x/y/z, force_x/y
// config    in         wr_en              wr_index, wr_data (gain_prop, gain_deriv)
//
// the front classifies a word in the cycle it is accepted and forms the forces
// the back loads a word, forms both squared errors and the p and d terms for x and y on
// one shared 33x33 multiplier, then writes the result register and only then takes the next word
// arst_n clears stamp, rest offsets, previous errors and the queue, and sets the gains to their reset values
// input stalls only when the queue is full; the back holds in its last step
// while the result register is occupied
module loadcell_compliance_pd_core #(
	parameter int unsigned QUEUE_DEPTH = lcpd_pkg::LCPD_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [31:0]        stamp,
	input  logic signed [31:0] cell_neg_x,
	input  logic signed [31:0] cell_pos_y,
	input  logic signed [31:0] cell_neg_y,
	input  logic signed [31:0] cell_pos_x,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] target_x,
	output logic signed [31:0] target_y,
	output logic signed [31:0] target_z,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [31:0]        wr_data
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	lcpd_pkg::item_t front_item;
	lcpd_pkg::item_t head_item;

	// front: filter and force vector
	lcpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.stamp      (stamp),
		.cell_neg_x (cell_neg_x),
		.cell_pos_y (cell_pos_y),
		.cell_neg_y (cell_neg_y),
		.cell_pos_x (cell_pos_x),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.q_push     (q_push),
		.q_item     (front_item),
		.q_full     (q_full)
	);

	// decoupling queue
	lcpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_item (front_item),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_item (head_item),
		.q_empty (q_empty)
	);

	// back: squared error and pd step
	lcpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.q_item   (head_item),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.force_x  (force_x),
		.force_y  (force_y)
	);

endmodule

// ===== sv/lcpd_front.sv =====
module lcpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           stamp,
	input  logic signed [31:0]    cell_neg_x,
	input  logic signed [31:0]    cell_pos_y,
	input  logic signed [31:0]    cell_neg_y,
	input  logic signed [31:0]    cell_pos_x,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	output logic                  q_push,
	output lcpd_pkg::item_t       q_item,
	input  logic                  q_full
);

	logic [31:0]        last_stamp_q;
	logic signed [31:0] rest_q [4];
	logic signed [31:0] reading [4];
	logic signed [31:0] rest [4];
	logic               accept;
	logic               dup;
	logic               blank;
	logic               capture;
	logic signed [47:0] diff_x;
	logic signed [47:0] diff_y;

	assign reading[0] = cell_neg_x;
	assign reading[1] = cell_pos_y;
	assign reading[2] = cell_neg_y;
	assign reading[3] = cell_pos_x;

	// classify the incoming word
	assign full    = q_full;
	assign accept  = push && !q_full;
	assign dup     = (stamp == last_stamp_q);
	assign blank   = (reading[0] == 32'sd0) && (reading[1] == 32'sd0) &&
		(reading[2] == 32'sd0) && (reading[3] == 32'sd0);
	assign q_push  = accept && !dup && !blank;
	assign capture = (rest_q[0] == 32'sd0);

	// offsets as seen by this word
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rest[i] = capture ? reading[i] : rest_q[i];
		end
	end

	// offset-corrected force vector
	always_comb begin
		diff_x = (48'(reading[3]) - 48'(rest[3])) - (48'(reading[0]) - 48'(rest[0]));
		diff_y = (48'(reading[1]) - 48'(rest[1])) - (48'(reading[2]) - 48'(rest[2]));
		q_item.fx    = lcpd_pkg::sat32(diff_x);
		q_item.fy    = lcpd_pkg::sat32(diff_y);
		q_item.pos_x = pos_x;
		q_item.pos_y = pos_y;
		q_item.pos_z = pos_z;
	end

	// stamp and rest offset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			for (int i = 0; i < 4; i++) begin
				rest_q[i] <= '0;
			end
		end else if (q_push) begin
			last_stamp_q <= stamp;
			if (capture) begin
				for (int i = 0; i < 4; i++) begin
					rest_q[i] <= reading[i];
				end
			end
		end
	end

endmodule

// ===== sv/lcpd_queue.sv =====
module lcpd_queue #(
	parameter int unsigned DEPTH = lcpd_pkg::LCPD_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  lcpd_pkg::item_t wr_item,
	output logic            q_full,
	input  logic            rd,
	output lcpd_pkg::item_t rd_item,
	output logic            q_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lcpd_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lcpd_back.sv =====
module lcpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [0:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  lcpd_pkg::item_t    q_item,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] target_x,
	output logic signed [31:0] target_y,
	output logic signed [31:0] target_z,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SQX  = 8'b0000_0010,
		ST_SQY  = 8'b0000_0100,
		ST_PX   = 8'b0000_1000,
		ST_DX   = 8'b0001_0000,
		ST_PY   = 8'b0010_0000,
		ST_DY   = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	state_t             state_nxt;
	logic [31:0]        gain_prop_q;
	logic [31:0]        gain_deriv_q;
	lcpd_pkg::item_t    item_q;
	logic signed [31:0] err_x_q;
	logic signed [31:0] err_y_q;
	logic signed [31:0] last_err_x_q;
	logic signed [31:0] last_err_y_q;
	logic signed [31:0] tgt_x_q;
	logic signed [47:0] acc_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] op_a;
	logic signed [32:0] op_b;
	logic               mul_en;
	logic signed [32:0] fx_w;
	logic signed [32:0] fy_w;
	logic signed [32:0] fx_abs;
	logic signed [32:0] fy_abs;
	logic signed [47:0] sq_term;
	logic signed [47:0] gain_term;
	logic               out_valid_q;
	logic               out_free;
	logic               finish;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic signed [31:0] out_z_q;
	logic signed [31:0] out_fx_q;
	logic signed [31:0] out_fy_q;

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= lcpd_pkg::GAIN_PROP_RST;
			gain_deriv_q <= lcpd_pkg::GAIN_DERIV_RST;
		end else if (wr_en) begin
			unique case (lcpd_pkg::reg_idx_t'(wr_index))
				lcpd_pkg::REG_GAIN_PROP:  gain_prop_q  <= wr_data;
				lcpd_pkg::REG_GAIN_DERIV: gain_deriv_q <= wr_data;
			endcase
		end
	end

	// operand shaping
	assign fx_w    = 33'(item_q.fx);
	assign fy_w    = 33'(item_q.fy);
	assign fx_abs  = fx_w[32] ? -fx_w : fx_w;
	assign fy_abs  = fy_w[32] ? -fy_w : fy_w;
	assign sq_term   = prod_q[63:16];
	assign gain_term = 48'($signed(prod_q[65:24]));

	assign out_free = !out_valid_q || pop;
	assign finish   = (state_q == ST_FIN) && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign mul_en   = (state_q != ST_IDLE) && (state_q != ST_FIN);

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_SQX: begin
				op_a = fx_w;
				op_b = fx_abs;
			end
			ST_SQY: begin
				op_a = -fy_w;
				op_b = fy_abs;
			end
			ST_PX: begin
				op_a = {1'b0, gain_prop_q};
				op_b = 33'(err_x_q);
			end
			ST_DX: begin
				op_a = {1'b0, gain_deriv_q};
				op_b = 33'(err_x_q) - 33'(last_err_x_q);
			end
			ST_PY: begin
				op_a = {1'b0, gain_prop_q};
				op_b = 33'(err_y_q);
			end
			ST_DY: begin
				op_a = {1'b0, gain_deriv_q};
				op_b = 33'(err_y_q) - 33'(last_err_y_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (!q_empty) state_nxt = ST_SQX;
			ST_SQX:  state_nxt = ST_SQY;
			ST_SQY:  state_nxt = ST_PX;
			ST_PX:   state_nxt = ST_DX;
			ST_DX:   state_nxt = ST_PY;
			ST_PY:   state_nxt = ST_DY;
			ST_DY:   state_nxt = ST_FIN;
			ST_FIN:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_err_x_q <= '0;
			last_err_y_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish) begin
				last_err_x_q <= err_x_q;
				last_err_y_q <= err_y_q;
				out_valid_q  <= 1'b1;
			end else if (pop) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// datapath: multiply, square, accumulate
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (mul_en) begin
			prod_q <= op_a * op_b;
		end
		unique case (state_q)
			ST_SQY: err_x_q <= lcpd_pkg::sat32(sq_term);
			ST_PX:  err_y_q <= lcpd_pkg::sat32(sq_term);
			ST_DX:  acc_q   <= 48'(item_q.pos_x) + gain_term;
			ST_PY:  acc_q   <= acc_q + gain_term;
			ST_DY: begin
				tgt_x_q <= lcpd_pkg::sat32(acc_q);
				acc_q   <= 48'(item_q.pos_y) + gain_term;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			out_x_q  <= tgt_x_q;
			out_y_q  <= lcpd_pkg::sat32(acc_q + gain_term);
			out_z_q  <= item_q.pos_z;
			out_fx_q <= item_q.fx;
			out_fy_q <= item_q.fy;
		end
	end

	assign empty    = !out_valid_q;
	assign target_x = out_x_q;
	assign target_y = out_y_q;
	assign target_z = out_z_q;
	assign force_x  = out_fx_q;
	assign force_y  = out_fy_q;

endmodule

// ===== tb/tb_loadcell_compliance_pd_core.sv =====
module tb_loadcell_compliance_pd_core;

	localparam int          RUN_LIMIT = 400000;
	localparam int          TAIL_WAIT = 40;
	localparam longint      S32_MAX   = 64'sd2147483647;
	localparam longint      S32_MIN   = -64'sd2147483648;
	localparam logic [31:0] W_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN     = 32'h8000_0000;

	// one input word: stamp, cells 0..3, position
	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] c_nx;
		logic [31:0] c_py;
		logic [31:0] c_ny;
		logic [31:0] c_px;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} sample_t;

	// one result word: commanded position and forces
	typedef struct packed {
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic [31:0] fx;
		logic [31:0] fy;
	} command_t;

	// directed row, with a hand-written command where it is obvious
	typedef struct packed {
		sample_t  s;
		bit       typed;
		bit       has_res;
		command_t want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [31:0]        stamp;
	logic signed [31:0] cell_neg_x;
	logic signed [31:0] cell_pos_y;
	logic signed [31:0] cell_neg_y;
	logic signed [31:0] cell_pos_x;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               empty;
	logic               pop;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic               wr_en;
	logic [0:0]         wr_index;
	logic [31:0]        wr_data;

	// controller state as the predictor sees it
	logic [31:0] kp;
	logic [31:0] kd;
	logic [31:0] seen_stamp;
	longint      rest [4];
	longint      prev_err [3];

	command_t    pending_cmds [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	row_t        plan [14];

	loadcell_compliance_pd_core dut (.*);

	// clock
	always begin
		#5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("** loadcell_compliance_pd_core: FAILED **");
			$finish;
		end
	end

	function automatic longint clamp32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic logic [63:0] abs64(input longint v);
		if (v < 0) return -v;
		return v;
	endfunction

	// floor of +-mag / 2^sh
	function automatic longint shr_floor(input logic [63:0] mag, input bit neg, input int sh);
		logic [63:0] q;
		q = mag >> sh;
		if (neg) begin
			if ((mag & ((64'd1 << sh) - 64'd1)) != 64'd0) q = q + 64'd1;
			return -longint'(q);
		end
		return longint'(q);
	endfunction

	// signed square of a force, Q16.16
	function automatic longint sq_error(input longint f, input bit flip);
		logic [63:0] m;
		m = abs64(f);
		if (f == 0) return 0;
		return clamp32(shr_floor(m * m, (f < 0) ^ flip, 16));
	endfunction

	// Q8.24 gain times a signed value
	function automatic longint gain_mul(input logic [31:0] g, input longint v);
		return shr_floor({32'd0, g} * abs64(v), v < 0, 24);
	endfunction

	// one PD step; returns 0 when the word is dropped
	function automatic bit predict_command(input sample_t s, output command_t c);
		longint rd [4];
		longint at [3];
		longint err [3];
		longint tgt [3];
		longint f_x;
		longint f_y;
		c = '0;
		rd[0] = longint'($signed(s.c_nx));
		rd[1] = longint'($signed(s.c_py));
		rd[2] = longint'($signed(s.c_ny));
		rd[3] = longint'($signed(s.c_px));
		at[0] = longint'($signed(s.px));
		at[1] = longint'($signed(s.py));
		at[2] = longint'($signed(s.pz));
		if (s.stamp == seen_stamp) return 0;
		if (rd[0] == 0 && rd[1] == 0 && rd[2] == 0 && rd[3] == 0) return 0;
		seen_stamp = s.stamp;
		// rest capture until offset 0 is nonzero
		if (rest[0] == 0) begin
			for (int i = 0; i < 4; i++) rest[i] = rd[i];
		end
		f_x = clamp32((rd[3] - rest[3]) - (rd[0] - rest[0]));
		f_y = clamp32((rd[1] - rest[1]) - (rd[2] - rest[2]));
		err[0] = sq_error(f_x, 1'b0);
		err[1] = sq_error(f_y, 1'b1);
		err[2] = 0;
		for (int i = 0; i < 3; i++) begin
			tgt[i] = clamp32(at[i] + gain_mul(kp, err[i]) + gain_mul(kd, err[i] - prev_err[i]));
			prev_err[i] = err[i];
		end
		c.tx = 32'(tgt[0]);
		c.ty = 32'(tgt[1]);
		c.tz = 32'(tgt[2]);
		c.fx = 32'(f_x);
		c.fy = 32'(f_y);
		return 1;
	endfunction

	// cell reading: mostly near its rest offset
	function automatic logic [31:0] pick_reading(input logic [31:0] center);
		int k;
		k = $urandom_range(9);
		if (k <= 5) return center + ($urandom_range(32'h0008_0000) - 32'h0004_0000);
		if (k <= 7) return center;
		if (k == 8) return $urandom;
		unique case ($urandom_range(2))
			0: return W_MAX;
			1: return W_MIN;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [31:0] pick_position();
		int k;
		k = $urandom_range(9);
		if (k <= 6) return $urandom_range(32'h0200_0000) - 32'h0100_0000;
		if (k <= 8) return $urandom;
		return $urandom_range(1) ? W_MAX : W_MIN;
	endfunction

	// random word: fresh stamps, some repeats and empty readings
	function automatic sample_t next_sample();
		sample_t s;
		int r;
		r = $urandom_range(99);
		s.stamp = (r < 8) ? seen_stamp : $urandom;
		if (r >= 8 && r < 13) begin
			s.c_nx = '0;
			s.c_py = '0;
			s.c_ny = '0;
			s.c_px = '0;
		end else begin
			s.c_nx = pick_reading(32'(rest[0]));
			s.c_py = pick_reading(32'(rest[1]));
			s.c_ny = pick_reading(32'(rest[2]));
			s.c_px = pick_reading(32'(rest[3]));
		end
		s.px = pick_position();
		s.py = pick_position();
		s.pz = pick_position();
		return s;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) flag($sformatf("%s: expected %h got %h", nm, want, got));
	endtask

	// send one word, predict once accepted
	task automatic send_sample(input sample_t s, output bit made, output command_t c);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		stamp      <= s.stamp;
		cell_neg_x <= s.c_nx;
		cell_pos_y <= s.c_py;
		cell_neg_y <= s.c_ny;
		cell_pos_x <= s.c_px;
		pos_x      <= s.px;
		pos_y      <= s.py;
		pos_z      <= s.pz;
		@(posedge clk);
		while (full) @(posedge clk);
		made = predict_command(s, c);
	endtask

	// wait until every command is back and dropped words have left the block
	task automatic settle();
		push <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	task automatic write_gains(input logic [31:0] p, input logic [31:0] d);
		wr_en    <= 1'b1;
		wr_index <= lcpd_pkg::REG_GAIN_PROP;
		wr_data  <= p;
		@(posedge clk);
		wr_index <= lcpd_pkg::REG_GAIN_DERIV;
		wr_data  <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		kp = p;
		kd = d;
		@(posedge clk);
	endtask

	// result side: check each popped word, random pop
	initial begin
		command_t want;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_cmds.size() == 0) begin
					flag($sformatf("unexpected word: %h %h %h %h %h",
						target_x, target_y, target_z, force_x, force_y));
				end else begin
					want = pending_cmds.pop_front();
					check_field("target_x", want.tx, target_x);
					check_field("target_y", want.ty, target_y);
					check_field("target_z", want.tz, target_z);
					check_field("force_x", want.fx, force_x);
					check_field("force_y", want.fy, force_y);
				end
			end
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	// stimulus
	initial begin
		bit          made;
		command_t    c;
		logic [31:0] ph_kp [6];
		logic [31:0] ph_kd [6];
		int          ph_n [6];
		int          ph_tx [6];
		int          ph_rx [6];

		arst_n     <= 1'b0;
		push       <= 1'b0;
		stamp      <= '0;
		cell_neg_x <= '0;
		cell_pos_y <= '0;
		cell_neg_y <= '0;
		cell_pos_x <= '0;
		pos_x      <= '0;
		pos_y      <= '0;
		pos_z      <= '0;
		wr_en      <= 1'b0;
		wr_index   <= lcpd_pkg::REG_GAIN_PROP;
		wr_data    <= '0;

		kp         = 32'h0100_0000;
		kd         = 32'd1678;
		seen_stamp = '0;
		for (int i = 0; i < 4; i++) rest[i] = 0;
		for (int i = 0; i < 3; i++) prev_err[i] = 0;

		// stamp 0 repeats the reset stamp
		plan[0]  = '{'{32'h0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000,
			32'h5_0000, 32'h6_0000, 32'h7_0000}, 1'b1, 1'b0, '0};
		// all cells zero
		plan[1]  = '{'{32'h1, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h1, 32'h2, 32'h3}, 1'b1, 1'b0, '0};
		// capture with cell 0 zero, zero force
		plan[2]  = '{'{32'h1, 32'h0, 32'h2_0000, 32'h3_0000, 32'h4_0000,
			32'h0064_0000, 32'hFF9C_0000, 32'h1234_5678}, 1'b1, 1'b1,
			'{32'h0064_0000, 32'hFF9C_0000, 32'h1234_5678, 32'h0, 32'h0}};
		// repeated stamp
		plan[3]  = '{'{32'h1, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000,
			32'h0, 32'h0, 32'h0}, 1'b1, 1'b0, '0};
		// capture again, position extremes pass through
		plan[4]  = '{'{32'h2, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000,
			W_MIN, W_MAX, 32'h0}, 1'b1, 1'b1,
			'{W_MIN, W_MAX, 32'h0, 32'h0, 32'h0}};
		// unit x force, offsets now fixed
		plan[5]  = '{'{32'h3, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h5_0000,
			32'h1_0000, 32'hFFFF_0000, 32'h1}, 1'b0, 1'b0, '0};
		// x force saturates high
		plan[6]  = '{'{32'hFFFF_FFFF, W_MIN, 32'h2_0000, 32'h3_0000, W_MAX,
			W_MAX, 32'hABCD_0000, 32'h1_0000}, 1'b1, 1'b1,
			'{W_MAX, 32'hABCD_0000, 32'h1_0000, W_MAX, 32'h0}};
		// x force saturates low
		plan[7]  = '{'{32'h0, W_MAX, 32'h2_0000, 32'h3_0000, W_MIN,
			W_MIN, 32'h0, 32'h0}, 1'b1, 1'b1,
			'{W_MIN, 32'h0, 32'h0, W_MIN, 32'h0}};
		// y force extremes
		plan[8]  = '{'{32'h5, 32'h1_0000, W_MAX, W_MIN, 32'h4_0000,
			32'h1000_0000, W_MIN, 32'hFFFF_FFFF}, 1'b0, 1'b0, '0};
		plan[9]  = '{'{32'h6, 32'h1_0000, W_MIN, W_MAX, 32'h4_0000,
			32'hF000_0000, W_MAX, W_MIN}, 1'b0, 1'b0, '0};
		// tiny forces, rounding toward minus infinity
		plan[10] = '{'{32'h7, 32'h1_8000, 32'h2_0000, 32'h2_FFFF, 32'h4_0000,
			32'h10_0000, 32'h20_0000, 32'h30_0000}, 1'b0, 1'b0, '0};
		plan[11] = '{'{32'h8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}, 1'b0, 1'b0, '0};
		plan[12] = '{'{32'h8, 32'h1, 32'h2, 32'h3, 32'h4,
			32'h0, 32'h0, 32'h0}, 1'b1, 1'b0, '0};
		// zero force, derivative only
		plan[13] = '{'{32'h9, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000,
			32'h3333_3333, 32'hCCCC_CCCC, 32'h0}, 1'b0, 1'b0, '0};

		// gain settings and idling per phase
		ph_kp = '{32'h0100_0000, 32'h0, 32'hFFFF_FFFF, $urandom,
			$urandom_range(32'h0200_0000), 32'h0080_0000};
		ph_kd = '{32'd1678, 32'h0, 32'hFFFF_FFFF, $urandom,
			$urandom_range(32'h0010_0000), 32'h0200_0000};
		ph_n  = '{80, 80, 80, 80, 80, 86};
		ph_tx = '{19, 19, 62, 62, 0, 0};
		ph_rx = '{62, 62, 19, 19, 0, 0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle = 19;
		rx_idle = 62;
		@(posedge clk);

		// directed rows at reset gains
		foreach (plan[i]) begin
			send_sample(plan[i].s, made, c);
			if (plan[i].typed) begin
				if (plan[i].has_res) pending_cmds.insert(pending_cmds.size(), plan[i].want);
			end else if (made) begin
				pending_cmds.insert(pending_cmds.size(), c);
			end
		end

		// random phases, gains changed only when drained
		for (int p = 0; p < 6; p++) begin
			settle();
			write_gains(ph_kp[p], ph_kd[p]);
			tx_idle = ph_tx[p];
			rx_idle = ph_rx[p];
			for (int n = 0; n < ph_n[p]; n++) begin
				send_sample(next_sample(), made, c);
				if (made) pending_cmds.insert(pending_cmds.size(), c);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("** loadcell_compliance_pd_core: PASSED **");
		end else begin
			$display("** loadcell_compliance_pd_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lcpd_pkg.sv
sv/lcpd_front.sv
sv/lcpd_queue.sv
sv/lcpd_back.sv
sv/loadcell_compliance_pd_core.sv
tb/tb_loadcell_compliance_pd_core.sv
